>>> src/amcs_pkg.sv
// shared types and constants for the absorbing markov chain solver
package amcs_pkg;

	typedef struct packed {
		logic clear_start;
		logic solve_start;
	} amcs_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic solve_done;
		logic out_empty;
	} amcs_sts_t;

	localparam int PROB_W = 17;
	localparam int IDX_W = 5;
	localparam int NS_W = 6;
	localparam int FX_W = 32;
	localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;
	localparam int DIV_STEPS = 64;

endpackage

>>> src/amcs_divider.sv
// restoring signed divider, one quotient bit per cycle, truncating toward zero
module amcs_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   dividend,
	input  logic signed [63:0]   divisor,
	output logic                 done,
	output logic signed [63:0]   quotient
);
	import amcs_pkg::*;

	logic [63:0] num_q, den_q, quo_q;
	logic [64:0] rem_q;
	logic        neg_q, busy_q;
	logic        dz_q, az_q, an_q;
	logic [6:0]  cnt_q;
	logic [64:0] trial;

	assign trial = {rem_q[63:0], num_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(DIV_STEPS);
				num_q <= dividend[63] ? 64'(-dividend) : dividend;
				den_q <= divisor[63] ? 64'(-divisor) : divisor;
				neg_q <= dividend[63] ^ divisor[63];
				dz_q <= (divisor == 64'sd0);
				az_q <= (dividend == 64'sd0);
				an_q <= dividend[63];
				rem_q <= '0;
				quo_q <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[62:0], 1'b0};
				if (!trial[64]) begin
					rem_q <= trial;
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[63:0], num_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// zero divisor gives the extreme of the dividend's sign, or zero
	assign quotient = dz_q ? (az_q ? 64'sd0 :
		(an_q ? 64'sh8000000000000000 : 64'sh7fffffffffffffff)) :
		(neg_q ? 64'(-quo_q) : quo_q);
endmodule

>>> src/amcs_datapath.sv
// edge store, elimination sequencer and result queue
module amcs_datapath #(
	parameter int MAX_STATES = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  amcs_pkg::amcs_cmd_t           cmd,
	output amcs_pkg::amcs_sts_t           sts,
	input  logic                          edge_we,
	input  logic [amcs_pkg::IDX_W-1:0]    edge_from,
	input  logic [amcs_pkg::IDX_W-1:0]    edge_to,
	input  logic [amcs_pkg::PROB_W-1:0]   edge_prob,
	input  logic [amcs_pkg::NS_W-1:0]     num_states,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [amcs_pkg::IDX_W-1:0]    res_index,
	output logic [amcs_pkg::PROB_W-1:0]   res_prob,
	output logic                          res_last
);
	import amcs_pkg::*;

	localparam int SW = $clog2(MAX_STATES);
	localparam int AW = 2 * SW;
	localparam int DEPTH = MAX_STATES * MAX_STATES;
	localparam int LIMIT = (MAX_STATES < 32) ? MAX_STATES : 32;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] MAXV = 64'sd2147483647;
	localparam logic signed [63:0] MINV = -64'sd2147483648;

	typedef enum logic [4:0] {
		P_IDLE, P_CLR, P_CLASS, P_BUILD_RD, P_BUILD_WR,
		P_PIV_RD, P_PIV_WAIT, P_DIV_RD, P_DIV_WAIT, P_DIVW, P_DIVI_WAIT, P_DIVIW,
		P_F_RD, P_F_WAIT, P_EL_RD, P_EL_WAIT, P_EL_MUL, P_EL_WR,
		P_MM_RD, P_MM_WAIT, P_MM_MUL, P_MM_ACC, P_SUM_RD, P_SUM_WAIT, P_SUM_ACC,
		P_DIVN, P_DIVN_WAIT, P_EMIT
	} ph_t;

	ph_t ph_q;

	logic [PROB_W-1:0] edge_mem [DEPTH];
	logic [FX_W-1:0]   work_mem [DEPTH];
	logic [FX_W-1:0]   inv_mem  [DEPTH];
	logic [FX_W-1:0]   abs_mem  [DEPTH];
	logic [SW-1:0]     trans_st [MAX_STATES];
	logic [SW-1:0]     abs_st   [MAX_STATES];
	logic [SW-1:0]     cls_pos  [MAX_STATES];
	logic [MAX_STATES-1:0] absf_q;

	logic [SW:0] n_q, t_q, a_q, i_q, j_q, k_q, r_q;
	logic [AW:0] clr_q;
	logic [PROB_W-1:0] e_rd_q;
	logic [FX_W-1:0]   w_rd_q, v_rd_q;
	logic signed [FX_W-1:0] piv_q, f_q, acc_q, x_q, y_q;
	logic signed [63:0] p1_s1, p2_s1;
	logic [AW-1:0] e_ra, m_ra;

	logic div_start;
	logic signed [63:0] div_a, div_d, div_quo;
	logic div_done;

	logic [IDX_W-1:0]  q_idx [32];
	logic [PROB_W-1:0] q_prb [32];
	logic [5:0]        q_cnt_q;
	logic [4:0]        q_rd_q;
	logic              clr_done_q, sol_done_q;

	amcs_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_d), .done(div_done), .quotient(div_quo)
	);

	function automatic logic signed [FX_W-1:0] sat(input logic signed [63:0] v);
		if (v > MAXV) return MAXV[FX_W-1:0];
		if (v < MINV) return MINV[FX_W-1:0];
		return v[FX_W-1:0];
	endfunction

	function automatic logic signed [FX_W-1:0] to_fx(input logic [PROB_W-1:0] p);
		logic [63:0] w;
		w = {47'd0, p};
		if (FRAC_BITS >= 16) return FX_W'(w << (FRAC_BITS - 16));
		return FX_W'(w >> (16 - FRAC_BITS));
	endfunction

	function automatic logic signed [FX_W-1:0] fl_shift(input logic signed [63:0] p);
		return sat(p >>> FRAC_BITS);
	endfunction

	function automatic logic [PROB_W-1:0] to_prob(input logic signed [FX_W-1:0] v);
		logic [63:0] u;
		if (v < 0) u = '0;
		else if (64'(v) > ONE) u = 64'(ONE);
		else u = 64'(unsigned'(v));
		if (FRAC_BITS >= 16) return PROB_W'(u >> (FRAC_BITS - 16));
		return PROB_W'(u << (16 - FRAC_BITS));
	endfunction

	function automatic logic [AW-1:0] ad(input logic [SW:0] r, input logic [SW:0] c);
		return AW'(r[SW-1:0]) * AW'(MAX_STATES) + AW'(c[SW-1:0]);
	endfunction

	always_comb begin
		e_ra = '0;
		m_ra = ad(i_q, j_q);
		unique case (ph_q)
			P_BUILD_RD: e_ra = ad({1'b0, trans_st[i_q[SW-1:0]]}, {1'b0, trans_st[j_q[SW-1:0]]});
			P_MM_RD, P_MM_WAIT: begin
				e_ra = ad({1'b0, trans_st[k_q[SW-1:0]]}, {1'b0, abs_st[j_q[SW-1:0]]});
				m_ra = ad(i_q, k_q);
			end
			P_PIV_RD: m_ra = ad(i_q, i_q);
			P_F_RD: m_ra = ad(r_q, i_q);
			P_EL_RD: m_ra = ad(r_q, j_q);
			P_SUM_RD, P_SUM_WAIT: m_ra = ad(k_q, {1'b0, cls_pos[i_q[SW-1:0]]});
			default: m_ra = ad(i_q, j_q);
		endcase
	end

	logic [AW-1:0] e_wa;
	assign e_wa = AW'(edge_from) * AW'(MAX_STATES) + AW'(edge_to);
	logic e_ok;
	assign e_ok = edge_we && (32'(edge_from) < MAX_STATES) && (32'(edge_to) < MAX_STATES);

	always_ff @(posedge clk) begin
		if (ph_q == P_CLR) edge_mem[clr_q[AW-1:0]] <= '0;
		else if (e_ok) edge_mem[e_wa] <= edge_prob;
		e_rd_q <= edge_mem[e_ra];
		w_rd_q <= work_mem[m_ra];
		v_rd_q <= (ph_q == P_SUM_RD || ph_q == P_SUM_WAIT) ? abs_mem[m_ra] : inv_mem[m_ra];
	end

	logic [AW-1:0] i_ra_row;
	always_ff @(posedge clk) begin
		unique case (ph_q)
			P_BUILD_WR: begin
				work_mem[ad(i_q, j_q)] <= sat(((i_q == j_q) ? ONE : 64'sd0) - 64'(to_fx(e_rd_q)));
				inv_mem[ad(i_q, j_q)] <= (i_q == j_q) ? FX_W'(ONE) : '0;
			end
			P_DIVW: if (div_done) work_mem[ad(i_q, j_q)] <= sat(div_quo);
			P_DIVIW: if (div_done) inv_mem[ad(i_q, j_q)] <= sat(div_quo);
			P_EL_WR: begin
				work_mem[ad(r_q, j_q)] <= sat(64'(x_q) - 64'(fl_shift(p1_s1)));
				inv_mem[ad(r_q, j_q)] <= sat(64'(y_q) - 64'(fl_shift(p2_s1)));
			end
			P_MM_ACC: if (k_q == t_q) abs_mem[ad(i_q, j_q)] <= acc_q;
			default: ;
		endcase
	end

	// row i values for elimination, fetched per column
	logic signed [FX_W-1:0] ri_w_q, ri_v_q;
	assign i_ra_row = ad(i_q, j_q);
	always_ff @(posedge clk) begin
		ri_w_q <= work_mem[i_ra_row];
		ri_v_q <= inv_mem[i_ra_row];
	end

	always_comb begin
		div_start = 1'b0;
		div_a = 64'(signed'(w_rd_q)) <<< FRAC_BITS;
		div_d = 64'(piv_q);
		unique case (ph_q)
			P_DIV_WAIT: div_start = 1'b1;
			P_DIVW: begin
				div_start = div_done;
				div_a = 64'(signed'(v_rd_q)) <<< FRAC_BITS;
			end
			P_DIVN: begin
				div_start = 1'b1;
				div_a = 64'(acc_q);
				div_d = 64'(n_q);
			end
			default: ;
		endcase
	end

	logic [SW:0] n_eff;
	always_comb begin
		n_eff = (num_states == '0) ? (SW+1)'(1) : (SW+1)'(num_states);
		if (32'(num_states) > LIMIT) n_eff = (SW+1)'(LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_CLR;
			absf_q <= '0;
			clr_q <= '0;
			q_cnt_q <= '0;
			q_rd_q <= '0;
			clr_done_q <= 1'b0;
			sol_done_q <= 1'b0;
		end else begin
			clr_done_q <= 1'b0;
			sol_done_q <= 1'b0;
			if (edge_we && e_ok && edge_from == edge_to && edge_prob == PROB_ONE)
				absf_q[SW'(edge_from)] <= 1'b1;
			if (res_valid && res_ready) begin
				q_rd_q <= q_rd_q + 5'd1;
				q_cnt_q <= q_cnt_q - 6'd1;
			end
			unique case (ph_q)
				P_IDLE: begin
					if (cmd.solve_start) begin
						ph_q <= P_CLASS;
						n_q <= n_eff;
						i_q <= '0;
						t_q <= '0;
						a_q <= '0;
						q_rd_q <= '0;
					end else if (cmd.clear_start) begin
						ph_q <= P_CLR;
						clr_q <= '0;
						absf_q <= '0;
					end
				end
				P_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DEPTH - 1)) begin
						ph_q <= P_IDLE;
						clr_done_q <= 1'b1;
					end
				end
				P_CLASS: begin
					if (i_q == n_q) begin
						ph_q <= P_BUILD_RD;
						i_q <= '0;
						j_q <= '0;
					end else begin
						if (absf_q[i_q[SW-1:0]]) begin
							cls_pos[i_q[SW-1:0]] <= a_q[SW-1:0];
							abs_st[a_q[SW-1:0]] <= i_q[SW-1:0];
							a_q <= a_q + 1'b1;
						end else begin
							cls_pos[i_q[SW-1:0]] <= t_q[SW-1:0];
							trans_st[t_q[SW-1:0]] <= i_q[SW-1:0];
							t_q <= t_q + 1'b1;
						end
						i_q <= i_q + 1'b1;
					end
				end
				P_BUILD_RD: begin
					if (i_q == t_q) begin
						ph_q <= P_PIV_RD;
						i_q <= '0;
					end else ph_q <= P_BUILD_WR;
				end
				P_BUILD_WR: begin
					ph_q <= P_BUILD_RD;
					if (j_q + 1'b1 == t_q) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else j_q <= j_q + 1'b1;
				end
				P_PIV_RD: begin
					if (i_q == t_q) begin
						ph_q <= P_MM_RD;
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						acc_q <= '0;
					end else ph_q <= P_PIV_WAIT;
				end
				P_PIV_WAIT: begin
					piv_q <= w_rd_q;
					j_q <= '0;
					r_q <= '0;
					if (64'(signed'(w_rd_q)) == ONE) ph_q <= P_F_RD;
					else ph_q <= P_DIV_RD;
				end
				P_DIV_RD: ph_q <= P_DIV_WAIT;
				P_DIV_WAIT: ph_q <= P_DIVW;
				P_DIVW: if (div_done) ph_q <= P_DIVIW;
				P_DIVIW: if (div_done) begin
					if (j_q + 1'b1 == t_q) begin
						j_q <= '0;
						ph_q <= P_F_RD;
					end else begin
						j_q <= j_q + 1'b1;
						ph_q <= P_DIV_RD;
					end
				end
				P_F_RD: begin
					if (r_q == t_q) begin
						i_q <= i_q + 1'b1;
						ph_q <= P_PIV_RD;
					end else if (r_q == i_q) r_q <= r_q + 1'b1;
					else begin
						ph_q <= P_F_WAIT;
						j_q <= '0;
					end
				end
				P_F_WAIT: begin
					f_q <= w_rd_q;
					ph_q <= P_EL_RD;
				end
				P_EL_RD: ph_q <= P_EL_WAIT;
				P_EL_WAIT: begin
					x_q <= w_rd_q;
					y_q <= v_rd_q;
					ph_q <= P_EL_MUL;
				end
				P_EL_MUL: begin
					p1_s1 <= 64'(f_q) * 64'(ri_w_q);
					p2_s1 <= 64'(f_q) * 64'(ri_v_q);
					ph_q <= P_EL_WR;
				end
				P_EL_WR: begin
					if (j_q + 1'b1 == t_q) begin
						r_q <= r_q + 1'b1;
						ph_q <= P_F_RD;
					end else begin
						j_q <= j_q + 1'b1;
						ph_q <= P_EL_RD;
					end
				end
				P_MM_RD: begin
					if (i_q == t_q) begin
						ph_q <= P_SUM_RD;
						i_q <= '0;
						k_q <= '0;
						acc_q <= '0;
						q_cnt_q <= '0;
					end else if (j_q == a_q) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else if (k_q == t_q) ph_q <= P_MM_ACC;
					else ph_q <= P_MM_WAIT;
				end
				P_MM_WAIT: ph_q <= P_MM_MUL;
				P_MM_MUL: begin
					p1_s1 <= 64'(signed'(v_rd_q)) * 64'(to_fx(e_rd_q));
					ph_q <= P_MM_ACC;
				end
				P_MM_ACC: begin
					ph_q <= P_MM_RD;
					if (k_q == t_q) begin
						k_q <= '0;
						acc_q <= '0;
						j_q <= j_q + 1'b1;
					end else begin
						acc_q <= sat(64'(acc_q) + 64'(fl_shift(p1_s1)));
						k_q <= k_q + 1'b1;
					end
				end
				P_SUM_RD: begin
					if (i_q == n_q) begin
						ph_q <= P_EMIT;
					end else if (!absf_q[i_q[SW-1:0]]) begin
						q_idx[IDX_W'(i_q)] <= IDX_W'(i_q);
						q_prb[IDX_W'(i_q)] <= '0;
						i_q <= i_q + 1'b1;
					end else if (k_q == t_q) begin
						acc_q <= sat(64'(acc_q) + ONE);
						ph_q <= P_DIVN;
					end else ph_q <= P_SUM_WAIT;
				end
				P_SUM_WAIT: ph_q <= P_SUM_ACC;
				P_SUM_ACC: begin
					acc_q <= sat(64'(acc_q) + 64'(signed'(v_rd_q)));
					k_q <= k_q + 1'b1;
					ph_q <= P_SUM_RD;
				end
				P_DIVN: ph_q <= P_DIVN_WAIT;
				P_DIVN_WAIT: if (div_done) begin
					q_idx[IDX_W'(i_q)] <= IDX_W'(i_q);
					q_prb[IDX_W'(i_q)] <= to_prob(sat(div_quo));
					i_q <= i_q + 1'b1;
					k_q <= '0;
					acc_q <= '0;
					ph_q <= P_SUM_RD;
				end
				P_EMIT: begin
					q_cnt_q <= 6'(n_q);
					q_rd_q <= '0;
					sol_done_q <= 1'b1;
					ph_q <= P_CLR;
					clr_q <= '0;
					absf_q <= '0;
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	assign sts = '{clear_done: clr_done_q, solve_done: sol_done_q,
		out_empty: (q_cnt_q == '0)};
	assign res_valid = (q_cnt_q != '0);
	assign res_index = q_idx[q_rd_q];
	assign res_prob = q_prb[q_rd_q];
	assign res_last = (q_cnt_q == 6'd1);

	a_last_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_last |-> res_valid) else $error("last without valid");
	a_idle_q: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != P_IDLE && ph_q != P_CLR) |-> !res_valid) else $error("queue busy in solve");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= 6'd32) else $error("queue overflow");
endmodule

>>> src/amcs_controller.sv
// job controller: edge loading, solve launch, clear wait and result drain
module amcs_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                in_last,
	output logic                in_open,
	output amcs_pkg::amcs_cmd_t cmd,
	input  amcs_pkg::amcs_sts_t sts
);
	import amcs_pkg::*;

	typedef enum logic [2:0] {S_LOAD, S_SOLVE, S_DRAIN, S_CLEAR} st_t;
	st_t st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
			cmd <= '0;
		end else begin
			cmd <= '0;
			unique case (st_q)
				S_LOAD: if (in_fire && in_last) begin
					cmd.solve_start <= 1'b1;
					st_q <= S_SOLVE;
				end
				S_SOLVE: if (sts.solve_done) st_q <= S_CLEAR;
				S_CLEAR: if (sts.clear_done) st_q <= S_DRAIN;
				S_DRAIN: if (sts.out_empty) st_q <= S_LOAD;
				default: st_q <= S_LOAD;
			endcase
		end
	end

	assign in_open = (st_q == S_LOAD) && !cmd.solve_start;

	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SOLVE) |-> !in_open) else $error("input open during solve");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_last) |=> cmd.solve_start) else $error("solve not started");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sts.solve_done |-> (st_q == S_SOLVE)) else $error("stray solve done");
endmodule

>>> src/absorbing_markov_chain_solver_core.sv
// Absorbing Markov chain solver: edges are taken one item per cycle and
// written into the edge store. The item marked last_edge closes the job:
// input stalls while a single sequencer forms I-Q, runs Gauss-Jordan
// elimination through one shared multiplier pair and a bit-serial divider
// (two quotients per divided element), then multiplies the inverse by R.
// Each absorbing state's result is its column sum of that product plus
// one, divided by the state count; each transient state's result is zero.
// Results then stream out from a queue, one per cycle while m_tready is
// high, as a clearing pass runs over all MAX_STATES*MAX_STATES edge store
// entries; the next edge is taken once both are done.
// The same clearing pass runs after reset before the first edge is taken.
module absorbing_markov_chain_solver_core #(
	parameter int MAX_STATES = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // from_state, to_state, prob
	input  logic        s_tlast,   // last_edge
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // state_index, absorb_prob
	output logic        m_tlast,   // last_result
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);
	import amcs_pkg::*;

	logic [NS_W-1:0] ns_q;
	amcs_cmd_t cmd;
	amcs_sts_t sts;
	logic in_open, in_fire;
	logic [PROB_W-1:0] p_sat;
	logic [IDX_W-1:0] r_idx;
	logic [PROB_W-1:0] r_prob;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ns_q <= 6'd32;
		else if (cfg_valid) ns_q <= cfg_data;
	end

	assign s_tready = in_open;
	assign in_fire = s_tvalid && s_tready;
	assign p_sat = (s_tdata[26:10] > PROB_ONE) ? PROB_ONE : s_tdata[26:10];

	amcs_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_tlast),
		.in_open(in_open), .cmd(cmd), .sts(sts)
	);

	amcs_datapath #(.MAX_STATES(MAX_STATES), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.edge_we(in_fire), .edge_from(s_tdata[4:0]), .edge_to(s_tdata[9:5]),
		.edge_prob(p_sat), .num_states(ns_q),
		.res_valid(m_tvalid), .res_ready(m_tready), .res_index(r_idx),
		.res_prob(r_prob), .res_last(m_tlast)
	);

	assign m_tdata = {2'b00, r_prob, r_idx};
endmodule

>>> tb/absorbing_markov_chain_solver_core_tb.sv
// self-checking testbench for the absorbing markov chain solver core
`timescale 1ns / 1ps
module absorbing_markov_chain_solver_core_tb;
	import amcs_pkg::*;

	typedef enum logic [1:0] {K_EDGE, K_CFG, K_DRAIN} kind_t;

	typedef struct {
		kind_t            kind;
		logic [IDX_W-1:0] src;
		logic [IDX_W-1:0] dst;
		logic [PROB_W-1:0] prob;
		logic             last;
		logic [NS_W-1:0]  ns;
	} stim_t;

	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [PROB_W-1:0] prob;
		logic              last;
	} res_t;

	localparam longint FX1 = 64'sd65536;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [23:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [5:0] cfg_data = '0;

	stim_t pend_q[$];
	res_t result_q[$];
	int errs = 0;
	logic s_done = 0, c_done = 0;
	int gap = 0, mgap = 0, settle = 0, sent = 0;

	// predictor copy of the block
	logic [PROB_W-1:0] edges[32][32];
	logic absorbing[32];
	logic [NS_W-1:0] num_cfg;
	int wm[32][32], im[32][32], am[32][32];

	absorbing_markov_chain_solver_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int sat32(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	function automatic int fmul(int a, int b);
		longint p;
		p = longint'(a) * longint'(b);
		return sat32(p >>> 16);
	endfunction

	function automatic int fdiv(int a, int d);
		if (d == 0) begin
			if (a > 0) return 32'h7fffffff;
			if (a < 0) return 32'h80000000;
			return 0;
		end
		return sat32((longint'(a) * FX1) / longint'(d));
	endfunction

	function automatic void clear_chain();
		foreach (edges[i, j]) edges[i][j] = '0;
		foreach (absorbing[i]) absorbing[i] = 0;
	endfunction

	function automatic void solve_chain();
		int n, t, a, s;
		int ts[32], abs_s[32], cp[32];
		int piv, f;
		res_t r;
		n = num_cfg;
		t = 0;
		a = 0;
		if (n == 0) n = 1;
		if (n > 32) n = 32;
		for (int i = 0; i < n; i++) begin
			if (absorbing[i]) begin
				cp[i] = a; abs_s[a++] = i;
			end else begin
				cp[i] = t; ts[t++] = i;
			end
		end
		for (int i = 0; i < t; i++)
			for (int j = 0; j < t; j++) begin
				wm[i][j] = sat32(((i == j) ? FX1 : 0) - longint'(edges[ts[i]][ts[j]]));
				im[i][j] = (i == j) ? int'(FX1) : 0;
			end
		for (int i = 0; i < t; i++) begin
			piv = wm[i][i];
			if (longint'(piv) != FX1)
				for (int j = 0; j < t; j++) begin
					wm[i][j] = fdiv(wm[i][j], piv);
					im[i][j] = fdiv(im[i][j], piv);
				end
			for (int rr = 0; rr < t; rr++) begin
				if (rr == i) continue;
				f = wm[rr][i];
				for (int j = 0; j < t; j++) begin
					wm[rr][j] = sat32(longint'(wm[rr][j]) - fmul(f, wm[i][j]));
					im[rr][j] = sat32(longint'(im[rr][j]) - fmul(f, im[i][j]));
				end
			end
		end
		for (int i = 0; i < t; i++)
			for (int j = 0; j < a; j++) begin
				am[i][j] = 0;
				for (int k = 0; k < t; k++)
					am[i][j] = sat32(longint'(am[i][j])
						+ fmul(im[i][k], int'(edges[ts[k]][abs_s[j]])));
			end
		for (int i = 0; i < n; i++) begin
			r.idx = i[4:0];
			r.prob = '0;
			r.last = (i == n - 1);
			if (absorbing[i]) begin
				s = 0;
				for (int k = 0; k < t; k++) s = sat32(longint'(s) + am[k][cp[i]]);
				s = sat32(longint'(s) + FX1);
				s = s / n;
				if (s < 0) s = 0;
				if (longint'(s) > FX1) s = int'(FX1);
				r.prob = s[16:0];
			end
			result_q.push_back(r);
		end
		clear_chain();
	endfunction

	function automatic void load_edge(logic [4:0] f, logic [4:0] d, logic [16:0] p, logic l);
		if (p > PROB_ONE) p = PROB_ONE;
		edges[f][d] = p;
		if (f == d && p == PROB_ONE) absorbing[f] = 1;
		if (l) solve_chain();
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sent % 60 < 15) return 0;
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// predictor and result checker
	always @(posedge clk) begin
		res_t e;
		s_done <= s_tvalid && s_tready;
		c_done <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) num_cfg = cfg_data;
			if (s_tvalid && s_tready)
				load_edge(s_tdata[4:0], s_tdata[9:5], s_tdata[26:10], s_tlast);
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$error("unexpected item idx=%0d", m_tdata[4:0]);
					errs++;
				end else begin
					e = result_q.pop_front();
					if (m_tdata[4:0] !== e.idx) begin
						$error("state_index exp %0d got %0d", e.idx, m_tdata[4:0]);
						errs++;
					end
					if (m_tdata[21:5] !== e.prob) begin
						$error("absorb_prob exp %0d got %0d", e.prob, m_tdata[21:5]);
						errs++;
					end
					if (m_tlast !== e.last) begin
						$error("last_result exp %0d got %0d", e.last, m_tlast);
						errs++;
					end
				end
			end
		end
	end

	// item driver
	always @(negedge clk) begin
		logic nv, ncv;
		stim_t it;
		nv = s_tvalid;
		ncv = cfg_valid;
		if (arst_n) begin
			if (s_done) nv = 0;
			if (c_done) ncv = 0;
			if (!nv && !ncv) begin
				if (gap > 0) gap--;
				else if (pend_q.size() != 0) begin
					it = pend_q[0];
					if (it.kind == K_EDGE) begin
						void'(pend_q.pop_front());
						s_tdata <= {5'd0, it.prob, it.dst, it.src};
						s_tlast <= it.last;
						nv = 1;
						sent++;
						gap = pick_gap();
					end else if (result_q.size() != 0) settle = 0;
					else if (settle < 100) settle++;
					else begin
						settle = 0;
						void'(pend_q.pop_front());
						if (it.kind == K_CFG) begin
							cfg_data <= it.ns;
							ncv = 1;
						end
					end
				end
			end
			s_tvalid <= nv;
			cfg_valid <= ncv;
			if (mgap > 0) begin
				mgap--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
				if ($urandom_range(0, 3) == 0) mgap = pick_gap();
			end
		end
	end

	task automatic add_edge(int f, int d, int p, bit l);
		stim_t it;
		it.kind = K_EDGE;
		it.src = f[4:0];
		it.dst = d[4:0];
		it.prob = p[16:0];
		it.last = l;
		it.ns = '0;
		pend_q.push_back(it);
	endtask

	task automatic add_ctl(kind_t k, int v);
		stim_t it;
		it.kind = k;
		it.src = '0;
		it.dst = '0;
		it.prob = '0;
		it.last = 0;
		it.ns = v[5:0];
		pend_q.push_back(it);
	endtask

	initial begin
		int n, cnt, k, f, d, p, nab;
		clear_chain();
		num_cfg = 6'd32;
		// reset value of num_states, field extremes and open cases
		add_edge(31, 31, 65536, 0);
		add_edge(30, 30, 70000, 0);
		add_edge(0, 31, 17'h1ffff, 0);
		add_edge(0, 1, 1, 0);
		add_edge(1, 30, 100000, 0);
		add_edge(2, 3, 40000, 0);
		add_edge(2, 3, 20000, 0);
		add_edge(31, 0, 30000, 0);
		add_edge(3, 31, 65535, 0);
		add_edge(0, 0, 0, 1);
		add_ctl(K_CFG, 1);
		add_edge(0, 0, 65536, 1);
		add_ctl(K_CFG, 0);
		add_edge(5, 3, 12345, 1);
		// zero pivot during elimination
		add_ctl(K_CFG, 3);
		add_edge(0, 1, 65536, 0);
		add_edge(1, 0, 65536, 0);
		add_edge(2, 2, 65536, 0);
		add_edge(1, 2, 5000, 1);
		// every state absorbing, plus an edge past n
		add_ctl(K_CFG, 2);
		add_edge(0, 0, 65536, 0);
		add_edge(1, 1, 65536, 0);
		add_edge(7, 1, 9000, 1);
		cnt = 0;
		while (cnt < 260) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
			add_ctl(K_CFG, n);
			if (n == 0) n = 1;
			nab = $urandom_range(0, (n + 1) / 2);
			for (int i = 0; i < nab; i++) begin
				f = $urandom_range(0, n - 1);
				add_edge(f, f, 65536, 0);
				cnt++;
			end
			k = $urandom_range(2, 12);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(0, 4) == 0) begin
					f = $urandom_range(0, 31);
					d = $urandom_range(0, 31);
					p = $urandom_range(0, 17'h1ffff);
				end else begin
					f = $urandom_range(0, n - 1);
					d = $urandom_range(0, n - 1);
					p = $urandom_range(0, 65536 / n + 2000);
				end
				add_edge(f, d, p, i == k - 1);
				cnt++;
			end
			if ($urandom_range(0, 7) == 0) add_ctl(K_DRAIN, 0);
		end
		add_ctl(K_CFG, 32);
		add_edge(0, 0, 65536, 0);
		add_edge(1, 0, 65536, 0);
		add_edge(2, 5, 65536, 0);
		add_edge(31, 31, 65536, 1);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		wait (pend_q.size() == 0);
		@(posedge clk);
		wait (!s_tvalid && !cfg_valid && result_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errs == 0 && result_q.size() == 0)
			$display("[absorbing_markov_chain_solver_core] OK");
		else
			$display("[absorbing_markov_chain_solver_core] ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("[absorbing_markov_chain_solver_core] ERROR");
		$finish;
	end

endmodule
